/* src/tcfq_pkg.sv */
// Shared types and constants for the two-class oldest-first FIFO.
package tcfq_pkg;

    localparam int ID_W          = 16;
    localparam int STAMP_W       = 16;
    localparam int DEPTH_DEF     = 16;
    localparam int ID_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        FUNC_ENQ     = 2'd0,
        FUNC_DEQ_ANY = 2'd1,
        FUNC_DEQ_C0  = 2'd2,
        FUNC_DEQ_C1  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage

/* src/two_class_fifo_oldest_first.sv */
// Top level of the two-class FIFO with oldest-first dequeue.
// Every transfer on the slave side is one operation (enqueue, dequeue oldest of either class,
// dequeue class 0, dequeue class 1) and gives exactly one result transfer on the master side.
// One operation is taken per clock while the master side is not stalled. A result passes
// through the input register and then the result register before it is held on the master
// side. A stalled master side holds both registers and the slave side.
// The queue heads are read ahead from each class memory so the oldest-entry choice needs no
// memory access in the operation cycle.
// Age is the arrival counter minus the entry's stamp, modulo 2^16; ties go to class 1.
// Queues come out of reset empty and need no clearing pass.
module two_class_fifo_oldest_first #(
    parameter int DEPTH   = tcfq_pkg::DEPTH_DEF,
    parameter int ID_BITS = tcfq_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] item_id
    input  logic [2:0]  s_axis_tuser,   // [1:0] func, [2] item_class
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_id
    output logic [2:0]  m_axis_tuser    // [1:0] status, [2] out_class
);
    import tcfq_pkg::*;

    localparam int IdW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int DW  = IdW + STAMP_W;

    logic           r_in_valid;
    t_func          r_in_func;
    logic           r_in_class;
    logic [IdW-1:0] r_in_id;
    logic           fire;
    t_q_ctl         ctl0, ctl1;
    t_q_flags       flags0, flags1;
    logic [DW-1:0]  head0, head1;
    logic [DW-1:0]  wr_data;
    t_status        status;
    logic           out_class;

    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func  <= t_func'(s_axis_tuser[1:0]);
            r_in_class <= s_axis_tuser[2];
            r_in_id    <= IdW'(s_axis_tdata);
        end
    end

    tcfq_queue #(.DEPTH(DEPTH), .DW(DW)) u_queue0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl0),
        .i_wr_data   (wr_data),
        .o_flags     (flags0),
        .o_head_data (head0)
    );

    tcfq_queue #(.DEPTH(DEPTH), .DW(DW)) u_queue1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl1),
        .i_wr_data   (wr_data),
        .o_flags     (flags1),
        .o_head_data (head1)
    );

    tcfq_ctrl #(.ID_WIDTH(IdW), .DW(DW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_func      (r_in_func),
        .i_class     (r_in_class),
        .i_id        (r_in_id),
        .i_flags0    (flags0),
        .i_flags1    (flags1),
        .i_head0     (head0),
        .i_head1     (head1),
        .i_m_ready   (m_axis_tready),
        .o_fire      (fire),
        .o_ctl0      (ctl0),
        .o_ctl1      (ctl1),
        .o_wr_data   (wr_data),
        .o_valid     (m_axis_tvalid),
        .o_status    (status),
        .o_out_id    (m_axis_tdata),
        .o_out_class (out_class)
    );

    assign m_axis_tuser = {out_class, status};

endmodule

/* src/tcfq_queue.sv */
// One class queue: entry memory, head/tail pointers, fill count and prefetched head entry.
module tcfq_queue #(
    parameter int DEPTH = tcfq_pkg::DEPTH_DEF,
    parameter int DW    = tcfq_pkg::ID_W + tcfq_pkg::STAMP_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcfq_pkg::t_q_ctl   i_ctl,
    input  logic [DW-1:0]      i_wr_data,
    output tcfq_pkg::t_q_flags o_flags,
    output logic [DW-1:0]      o_head_data
);
    import tcfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] Full    = CW'(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_head_data;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = (r_tail == LastIdx) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_head  = (r_head == LastIdx) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // head is read ahead; a push into an empty queue is forwarded
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_wr_data;
        end
        if (i_ctl.push && (r_tail == n_head)) begin
            r_head_data <= i_wr_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == Full);
    assign o_head_data   = r_head_data;

endmodule

/* src/tcfq_ctrl.sv */
// Operation decode, oldest-entry choice, arrival counter and result register.
module tcfq_ctrl #(
    parameter int ID_WIDTH = tcfq_pkg::ID_W,
    parameter int DW       = tcfq_pkg::ID_W + tcfq_pkg::STAMP_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  tcfq_pkg::t_func             i_func,
    input  logic                        i_class,
    input  logic [ID_WIDTH-1:0]         i_id,
    input  tcfq_pkg::t_q_flags          i_flags0,
    input  tcfq_pkg::t_q_flags          i_flags1,
    input  logic [DW-1:0]               i_head0,
    input  logic [DW-1:0]               i_head1,
    input  logic                        i_m_ready,
    output logic                        o_fire,
    output tcfq_pkg::t_q_ctl            o_ctl0,
    output tcfq_pkg::t_q_ctl            o_ctl1,
    output logic [DW-1:0]               o_wr_data,
    output logic                        o_valid,
    output tcfq_pkg::t_status           o_status,
    output logic [tcfq_pkg::ID_W-1:0]   o_out_id,
    output logic                        o_out_class
);
    import tcfq_pkg::*;

    logic                r_valid;
    t_status             r_status, n_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic                r_out_class;
    logic [STAMP_W-1:0]  r_arrival;
    logic                enq_ok;
    logic                deq;
    logic                sel;
    logic [STAMP_W-1:0]  age0, age1;

    assign o_fire = i_valid && (!r_valid || i_m_ready);

    assign age0 = r_arrival - i_head0[DW-1:ID_WIDTH];
    assign age1 = r_arrival - i_head1[DW-1:ID_WIDTH];

    always_comb begin
        enq_ok   = 1'b0;
        deq      = 1'b0;
        sel      = 1'b0;
        n_status = ST_EMPTY;
        unique case (i_func)
            FUNC_ENQ: begin
                if (i_class ? i_flags1.full : i_flags0.full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_ENQ;
                    enq_ok   = 1'b1;
                end
            end
            FUNC_DEQ_ANY: begin
                priority if (i_flags0.empty && i_flags1.empty) begin
                    deq = 1'b0;
                end else if (i_flags0.empty) begin
                    deq = 1'b1;
                    sel = 1'b1;
                end else if (i_flags1.empty) begin
                    deq = 1'b1;
                end else begin
                    deq = 1'b1;
                    sel = !(age0 > age1);   // equal ages: class 1 leaves
                end
            end
            FUNC_DEQ_C0: begin
                deq = !i_flags0.empty;
            end
            FUNC_DEQ_C1: begin
                deq = !i_flags1.empty;
                sel = 1'b1;
            end
            default: begin
                deq = 1'b0;
            end
        endcase
        if (deq) begin
            n_status = ST_DEQ;
        end
        n_out_id = '0;
        if (deq) begin
            n_out_id = sel ? ID_W'(i_head1[ID_WIDTH-1:0]) : ID_W'(i_head0[ID_WIDTH-1:0]);
        end
    end

    assign o_ctl0.push = o_fire && enq_ok && !i_class;
    assign o_ctl1.push = o_fire && enq_ok && i_class;
    assign o_ctl0.pop  = o_fire && deq && !sel;
    assign o_ctl1.pop  = o_fire && deq && sel;
    assign o_wr_data   = {r_arrival, i_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_arrival <= '0;
        end else begin
            if (o_fire) begin
                r_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_valid <= 1'b0;
            end
            if (o_fire && enq_ok) begin
                r_arrival <= r_arrival + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fire) begin
            r_status    <= n_status;
            r_out_id    <= n_out_id;
            r_out_class <= deq && sel;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_class = r_out_class;

endmodule

/* src/tcfq_checker.sv */
// Port-level checks for the two-class FIFO, bound to the top level.
module tcfq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [2:0]  i_m_tuser
);
    import tcfq_pkg::*;

    // only a dequeue result carries an id and class
    a_zero_unless_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && (i_m_tuser[1:0] != ST_DEQ)) |-> ((i_m_tdata == '0) && !i_m_tuser[2]))
        else $error("non-dequeue result carries data");

    // with the result register free the input side must be open
    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input stalled with empty result register");

    // an accepted operation moves through the input and result registers to the output when not back-pressured
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) ##1 i_m_tready |=> i_m_tvalid)
        else $error("result missing after transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed");

endmodule

bind two_class_fifo_oldest_first tcfq_checker u_tcfq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

/* tb/tb_two_class_fifo_oldest_first.sv */
// Self-checking testbench for the two-class oldest-first FIFO, with its own queue predictor.
`timescale 1ns / 1ps

module tb_two_class_fifo_oldest_first;
    import tcfq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int PLAN_ROWS      = 13;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } t_slot;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] id;
        logic            cls;
    } t_outcome;

    typedef struct packed {
        t_func           f;
        logic            c;
        logic [ID_W-1:0] id;
        logic [4:0]      reps;
        logic            typed;
        t_outcome        want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] item_id
    logic [2:0]  s_axis_tuser = '0;   // [1:0] func, [2] item_class
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;        // [15:0] out_id
    logic [2:0]  m_axis_tuser;        // [1:0] status, [2] out_class

    t_slot              class0_q[$];
    t_slot              class1_q[$];
    logic [STAMP_W-1:0] arrival_stamp = '0;
    t_outcome           pending_q[$];

    logic     cur_typed = 1'b0;
    t_outcome cur_want = '0;
    logic     calm = 1'b0;
    int       stall_left = 0;
    int       idle_cycles = 0;
    int       errors = 0;
    t_row     plan [0:PLAN_ROWS-1];

    two_class_fifo_oldest_first DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_outcome mk(input t_status s, input logic [ID_W-1:0] id, input logic c);
        t_outcome r;
        r.status = s;
        r.id     = id;
        r.cls    = c;
        return r;
    endfunction

    function automatic t_outcome fifo_outcome(input t_func f, input logic c,
                                              input logic [ID_W-1:0] id);
        t_outcome           r;
        t_slot              s;
        logic [STAMP_W-1:0] age0;
        logic [STAMP_W-1:0] age1;
        logic               pick;
        logic               found;
        r     = mk(ST_EMPTY, '0, 1'b0);
        pick  = 1'b0;
        found = 1'b0;
        case (f)
            FUNC_ENQ: begin
                s.id    = id;
                s.stamp = arrival_stamp;
                if ((c ? class1_q.size() : class0_q.size()) >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (c) class1_q.insert(class1_q.size(), s);
                    else class0_q.insert(class0_q.size(), s);
                    arrival_stamp = arrival_stamp + 1'b1;
                    r.status = ST_ENQ;
                end
            end
            FUNC_DEQ_ANY: begin
                if (class0_q.size() == 0 && class1_q.size() == 0) begin
                    found = 1'b0;
                end else if (class0_q.size() == 0) begin
                    found = 1'b1;
                    pick  = 1'b1;
                end else if (class1_q.size() == 0) begin
                    found = 1'b1;
                    pick  = 1'b0;
                end else begin
                    age0  = arrival_stamp - class0_q[0].stamp;
                    age1  = arrival_stamp - class1_q[0].stamp;
                    found = 1'b1;
                    pick  = !(age0 > age1);   // tie goes to class 1
                end
            end
            FUNC_DEQ_C0: begin
                found = (class0_q.size() != 0);
                pick  = 1'b0;
            end
            default: begin
                found = (class1_q.size() != 0);
                pick  = 1'b1;
            end
        endcase
        if (f != FUNC_ENQ && found) begin
            if (pick) begin
                s = class1_q[0];
                class1_q.delete(0);
            end else begin
                s = class0_q[0];
                class0_q.delete(0);
            end
            r = mk(ST_DEQ, s.id, pick);
        end
        return r;
    endfunction

    task automatic send_op(input t_func f, input logic c, input logic [ID_W-1:0] id,
                           input logic typed, input t_outcome want);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= {c, f};
        cur_typed = typed;
        cur_want  = want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        t_outcome got;
        logic     busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                busy = 1'b1;
                got  = mk(t_status'(m_axis_tuser[1:0]), m_axis_tdata, m_axis_tuser[2]);
                if (pending_q.size() == 0) begin
                    $error("result transfer with nothing pending: status %0d id %h class %0d",
                           got.status, got.id, got.cls);
                    errors = errors + 1;
                end else begin
                    want = pending_q[0];
                    pending_q.delete(0);
                    if (got.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    if (got.id !== want.id)
                        $error("out_id: expected %h, got %h", want.id, got.id);
                    if (got.cls !== want.cls)
                        $error("out_class: expected %0d, got %0d", want.cls, got.cls);
                    if (got !== want) errors = errors + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                busy = 1'b1;
                want = fifo_outcome(t_func'(s_axis_tuser[1:0]), s_axis_tuser[2], s_axis_tdata);
                pending_q.insert(pending_q.size(), cur_typed ? cur_want : want);
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("two_class_fifo_oldest_first verification failed");
        $finish;
    end

    initial begin
        int       enq_weight;
        t_func    f;
        t_outcome none;
        none = mk(ST_ENQ, '0, 1'b0);

        plan[0]  = '{FUNC_DEQ_ANY, 1'b0, 16'h0000, 5'd1,  1'b1, mk(ST_EMPTY, 16'h0, 1'b0)};
        plan[1]  = '{FUNC_DEQ_C0,  1'b1, 16'hFFFF, 5'd1,  1'b1, mk(ST_EMPTY, 16'h0, 1'b0)};
        plan[2]  = '{FUNC_DEQ_C1,  1'b0, 16'h0000, 5'd1,  1'b1, mk(ST_EMPTY, 16'h0, 1'b0)};
        plan[3]  = '{FUNC_ENQ,     1'b0, 16'h0000, 5'd1,  1'b1, mk(ST_ENQ, 16'h0, 1'b0)};
        plan[4]  = '{FUNC_ENQ,     1'b1, 16'hFFFF, 5'd1,  1'b1, mk(ST_ENQ, 16'h0, 1'b0)};
        plan[5]  = '{FUNC_DEQ_ANY, 1'b1, 16'h1234, 5'd1,  1'b1, mk(ST_DEQ, 16'h0000, 1'b0)};
        plan[6]  = '{FUNC_DEQ_ANY, 1'b0, 16'h0000, 5'd1,  1'b1, mk(ST_DEQ, 16'hFFFF, 1'b1)};
        // fill class 1 to the brim, then one more is dropped
        plan[7]  = '{FUNC_ENQ,     1'b1, 16'h5A50, 5'd16, 1'b1, mk(ST_ENQ, 16'h0, 1'b0)};
        plan[8]  = '{FUNC_ENQ,     1'b1, 16'hA5A5, 5'd1,  1'b1, mk(ST_FULL, 16'h0, 1'b0)};
        plan[9]  = '{FUNC_ENQ,     1'b0, 16'h8001, 5'd1,  1'b1, mk(ST_ENQ, 16'h0, 1'b0)};
        plan[10] = '{FUNC_DEQ_ANY, 1'b0, 16'h0000, 5'd1,  1'b0, none};
        plan[11] = '{FUNC_DEQ_C0,  1'b1, 16'hFFFF, 5'd1,  1'b0, none};
        plan[12] = '{FUNC_DEQ_C0,  1'b0, 16'h0000, 5'd1,  1'b1, mk(ST_EMPTY, 16'h0, 1'b0)};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
            for (int k = 0; k < plan[r].reps; k++)
                send_op(plan[r].f, plan[r].c, plan[r].id + ID_W'(k), plan[r].typed,
                        plan[r].want);

        // blocks lean towards filling, draining or balance so levels swing end to end
        for (int blk = 0; blk < 13; blk++) begin
            enq_weight = 2 + 3 * $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            if (blk == 7) wait_for_results();
            for (int n = 0; n < 50; n++) begin
                f = ($urandom_range(0, 9) < enq_weight) ? FUNC_ENQ : t_func'($urandom_range(1, 3));
                send_op(f, 1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 65535)), 1'b0,
                        none);
            end
        end

        // drain both classes back to back, then one arrival per class and three oldest-first
        wait_for_results();
        calm = 1'b1;
        for (int n = 0; n < DEPTH; n++) begin
            send_op(FUNC_DEQ_C0, 1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 65535)),
                    1'b0, none);
            send_op(FUNC_DEQ_C1, 1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 65535)),
                    1'b0, none);
        end
        send_op(FUNC_ENQ, 1'b1, ID_W'($urandom_range(0, 65535)), 1'b0, none);
        send_op(FUNC_ENQ, 1'b0, ID_W'($urandom_range(0, 65535)), 1'b0, none);
        send_op(FUNC_DEQ_ANY, 1'b0, 16'h0000, 1'b0, none);
        send_op(FUNC_DEQ_ANY, 1'b1, 16'hFFFF, 1'b0, none);
        send_op(FUNC_DEQ_ANY, 1'b0, 16'h0000, 1'b0, none);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("two_class_fifo_oldest_first verification clean");
        end else begin
            if (pending_q.size() != 0)
                $error("%0d expected results never arrived", pending_q.size());
            $display("two_class_fifo_oldest_first verification failed");
        end
        $finish;
    end

endmodule
